[rtl/gdsp_pkg.sv]
package gdsp_pkg;

  localparam int unsigned GDSP_QUEUE_DEPTH = 4;

  localparam logic [15:0] REC_BGNLIB   = 16'h0102;
  localparam logic [15:0] REC_UNITS    = 16'h0305;
  localparam logic [15:0] REC_ENDLIB   = 16'h0400;
  localparam logic [15:0] REC_BGNSTR   = 16'h0502;
  localparam logic [15:0] REC_ENDSTR   = 16'h0700;
  localparam logic [15:0] REC_BOUNDARY = 16'h0800;
  localparam logic [15:0] REC_PATH     = 16'h0900;
  localparam logic [15:0] REC_SREF     = 16'h0A00;
  localparam logic [15:0] REC_LAYER    = 16'h0D02;
  localparam logic [15:0] REC_WIDTH    = 16'h0F03;
  localparam logic [15:0] REC_XY       = 16'h1003;
  localparam logic [15:0] REC_ENDEL    = 16'h1100;
  localparam logic [15:0] REC_STRANS   = 16'h1A01;
  localparam logic [15:0] REC_MAG      = 16'h1B05;
  localparam logic [15:0] REC_ANGLE    = 16'h1C05;
  localparam logic [15:0] REC_PATHTYPE = 16'h2102;
  localparam logic [15:0] REC_BOX      = 16'h2D00;

  localparam logic [4:0] EV_BGNLIB   = 5'd0;
  localparam logic [4:0] EV_ENDLIB   = 5'd1;
  localparam logic [4:0] EV_BGNSTR   = 5'd2;
  localparam logic [4:0] EV_ENDSTR   = 5'd3;
  localparam logic [4:0] EV_BOUNDARY = 5'd4;
  localparam logic [4:0] EV_BOX      = 5'd5;
  localparam logic [4:0] EV_PATH     = 5'd6;
  localparam logic [4:0] EV_SREF     = 5'd7;
  localparam logic [4:0] EV_ENDEL    = 5'd8;
  localparam logic [4:0] EV_VERTEX   = 5'd9;
  localparam logic [4:0] EV_ORIGIN   = 5'd10;
  localparam logic [4:0] EV_LAYER    = 5'd11;
  localparam logic [4:0] EV_WIDTH    = 5'd12;
  localparam logic [4:0] EV_PATHTYPE = 5'd13;
  localparam logic [4:0] EV_FLIP     = 5'd14;
  localparam logic [4:0] EV_MAG      = 5'd15;
  localparam logic [4:0] EV_ANGLE    = 5'd16;
  localparam logic [4:0] EV_UNITS    = 5'd17;
  localparam logic [4:0] EV_STREAM   = 5'd18;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OPEN     = 3'd1;
  localparam logic [2:0] ST_CUT      = 3'd2;
  localparam logic [2:0] ST_NEST     = 3'd3;
  localparam logic [2:0] ST_OUTSIDE  = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;
  localparam logic [2:0] ST_CONFLICT = 3'd6;

  typedef enum logic [1:0] {
    ELEM_NONE,
    ELEM_BOUNDARY,
    ELEM_BOX,
    ELEM_PATH
  } elem_t;

  typedef enum logic [3:0] {
    OP_END,
    OP_SHORT,
    OP_HEADER,
    OP_XY,
    OP_UNITS,
    OP_MAG,
    OP_ANGLE,
    OP_LAYER,
    OP_WIDTH,
    OP_PATHTYPE,
    OP_STRANS
  } op_t;

  typedef enum logic [2:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef struct packed {
    op_t         op;
    logic        flag;
    logic [2:0]  code;
    logic [63:0] data;
  } q_entry_t;

endpackage

[rtl/gdsp_in_if.sv]
interface gdsp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] stream_byte;

  modport source (output valid, output kind, output stream_byte, input ready);
  modport sink (input valid, input kind, input stream_byte, output ready);
endinterface

[rtl/gdsp_out_if.sv]
interface gdsp_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         event_res;
  logic [2:0]         status;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic [63:0]        raw_real;

  modport source (output valid, output event_res, output status, output first_value,
                  output second_value, output raw_real, input ready);
  modport sink (input valid, input event_res, input status, input first_value,
                input second_value, input raw_real, output ready);
endinterface

[rtl/gdsp_front.sv]
module gdsp_front
  import gdsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  gdsp_in_if.sink  bytes,
  input  logic     full,
  output logic     push,
  output q_entry_t entry
);

  phase_t      phase, phase_next;
  logic [15:0] record_length, record_length_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] data_count, data_count_next;
  logic [63:0] gather, gather_next;
  logic [31:0] x_hold, x_hold_next;

  logic        fire;
  logic [15:0] len_full;
  logic [15:0] type_full;
  logic [15:0] count_inc;
  logic        last;
  logic [63:0] byte_w;
  logic [63:0] lane_ins;
  logic [31:0] x_ins;

  assign bytes.ready = !full;
  assign fire        = bytes.valid && bytes.ready;
  assign len_full    = {record_length[15:8], bytes.stream_byte};
  assign type_full   = {record_type[15:8], bytes.stream_byte};
  assign count_inc   = data_count + 16'd1;
  assign last        = count_inc == record_length;
  assign byte_w      = {56'd0, bytes.stream_byte};
  assign lane_ins    = byte_w << {~data_count[2:0], 3'b000};
  assign x_ins       = {24'd0, bytes.stream_byte} << {~data_count[1:0], 3'b000};

  always_comb begin
    phase_next = phase;
    if (fire) begin
      if (bytes.kind) begin
        phase_next = PH_LEN_HI;
      end else begin
        case (phase)
          PH_LEN_HI:  phase_next = PH_LEN_LO;
          PH_LEN_LO:  phase_next = (len_full < 16'd4) ? PH_HALT : PH_TYPE_HI;
          PH_TYPE_HI: phase_next = PH_TYPE_LO;
          PH_TYPE_LO: phase_next = (record_length != 16'd0) ? PH_DATA : PH_LEN_HI;
          PH_DATA:    phase_next = last ? PH_LEN_HI : PH_DATA;
          PH_HALT:    phase_next = PH_HALT;
          default:    phase_next = PH_LEN_HI;
        endcase
      end
    end
  end

  always_comb begin
    push               = 1'b0;
    entry.op           = OP_END;
    entry.flag         = 1'b0;
    entry.code         = ST_OK;
    entry.data         = '0;
    record_length_next = record_length;
    record_type_next   = record_type;
    data_count_next    = data_count;
    gather_next        = gather;
    x_hold_next        = x_hold;
    if (fire) begin
      if (bytes.kind) begin
        push = 1'b1;
        entry.op = OP_END;
        case (phase)
          PH_TYPE_HI, PH_TYPE_LO: entry.code = ST_CUT;
          PH_DATA:                entry.code = ST_SHORT;
          default:                entry.code = ST_OK;
        endcase
        record_length_next = '0;
        record_type_next   = '0;
        data_count_next    = '0;
        gather_next        = '0;
        x_hold_next        = '0;
      end else begin
        case (phase)
          PH_LEN_HI: record_length_next = {bytes.stream_byte, 8'd0};
          PH_LEN_LO: begin
            if (len_full < 16'd4) begin
              push = 1'b1;
              entry.op = OP_SHORT;
            end else begin
              record_length_next = len_full - 16'd4;
            end
          end
          PH_TYPE_HI: record_type_next = {bytes.stream_byte, 8'd0};
          PH_TYPE_LO: begin
            record_type_next = type_full;
            data_count_next  = '0;
            gather_next      = '0;
            x_hold_next      = '0;
            push             = 1'b1;
            entry.op         = OP_HEADER;
            entry.data       = {48'd0, type_full};
          end
          PH_DATA: begin
            data_count_next = count_inc;
            case (record_type)
              REC_XY: begin
                gather_next = ((data_count[2:0] == 3'd0) ? 64'd0 : gather) | lane_ins;
                if (data_count[2:0] == 3'd7) begin
                  push       = 1'b1;
                  entry.op   = OP_XY;
                  entry.flag = data_count == 16'd7;
                  entry.data = gather_next;
                end
              end
              REC_UNITS: begin
                if (data_count[15:3] == 13'd1) begin
                  gather_next = gather | lane_ins;
                end
                if (last) begin
                  push       = 1'b1;
                  entry.op   = OP_UNITS;
                  entry.flag = record_length == 16'd16;
                  entry.data = gather_next;
                end
              end
              REC_MAG, REC_ANGLE: begin
                if (data_count[15:3] == 13'd0) begin
                  gather_next = gather | lane_ins;
                end
                if (last) begin
                  push       = 1'b1;
                  entry.op   = (record_type == REC_MAG) ? OP_MAG : OP_ANGLE;
                  entry.data = gather_next;
                end
              end
              REC_LAYER, REC_WIDTH, REC_PATHTYPE, REC_STRANS: begin
                if (data_count[15:2] == 14'd0) begin
                  x_hold_next = x_hold | x_ins;
                end
                if (last) begin
                  push = 1'b1;
                  case (record_type)
                    REC_LAYER:    entry.op = OP_LAYER;
                    REC_WIDTH:    entry.op = OP_WIDTH;
                    REC_PATHTYPE: entry.op = OP_PATHTYPE;
                    default:      entry.op = OP_STRANS;
                  endcase
                  entry.data = {32'd0, x_hold_next};
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN_HI;
      record_length <= '0;
      record_type   <= '0;
      data_count    <= '0;
      gather        <= '0;
      x_hold        <= '0;
    end else begin
      phase         <= phase_next;
      record_length <= record_length_next;
      record_type   <= record_type_next;
      data_count    <= data_count_next;
      gather        <= gather_next;
      x_hold        <= x_hold_next;
    end
  end

endmodule

[rtl/gdsp_queue.sv]
module gdsp_queue
  import gdsp_pkg::*;
#(
  parameter int unsigned DEPTH = GDSP_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wr_entry,
  output logic     full,
  output logic     valid,
  output q_entry_t rd_entry,
  input  logic     pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  q_entry_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = count == FULL_COUNT;
  assign valid    = count != '0;
  assign rd_entry = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/gdsp_back.sv]
module gdsp_back
  import gdsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  q_entry_t   entry,
  output logic       pop,
  gdsp_out_if.source events
);

  logic        library_open, library_open_next;
  logic        cell_open, cell_open_next;
  elem_t       element_kind, element_kind_next;
  logic        reference_open, reference_open_next;
  logic        stopped, stopped_next;
  logic [2:0]  stop_code, stop_code_next;

  logic        out_valid;
  logic [4:0]  out_event;
  logic [2:0]  out_status;
  logic [31:0] out_first;
  logic [31:0] out_second;
  logic [63:0] out_real;

  logic        emit;
  logic [4:0]  ev;
  logic [2:0]  st;
  logic [31:0] first_v;
  logic [31:0] second_v;
  logic [63:0] real_v;
  logic        any_open;
  logic        elem_on;

  assign pop      = q_valid && (!out_valid || events.ready);
  assign any_open = library_open || cell_open || (element_kind != ELEM_NONE) || reference_open;
  assign elem_on  = element_kind != ELEM_NONE;

  always_comb begin
    library_open_next   = library_open;
    cell_open_next      = cell_open;
    element_kind_next   = element_kind;
    reference_open_next = reference_open;
    stopped_next        = stopped;
    stop_code_next      = stop_code;
    emit                = 1'b0;
    ev                  = EV_STREAM;
    st                  = ST_OK;
    first_v             = '0;
    second_v            = '0;
    real_v              = '0;
    if (pop) begin
      if (entry.op == OP_END) begin
        emit = 1'b1;
        ev   = EV_STREAM;
        if (stopped) begin
          st = stop_code;
        end else if (entry.code == ST_OK) begin
          st = any_open ? ST_OPEN : ST_OK;
        end else begin
          st = entry.code;
        end
        library_open_next   = 1'b0;
        cell_open_next      = 1'b0;
        element_kind_next   = ELEM_NONE;
        reference_open_next = 1'b0;
        stopped_next        = 1'b0;
        stop_code_next      = ST_OK;
      end else if (!stopped) begin
        case (entry.op)
          OP_SHORT: begin
            stopped_next   = 1'b1;
            stop_code_next = any_open ? ST_OPEN : ST_OK;
          end
          OP_HEADER: begin
            case (entry.data[15:0])
              REC_BGNLIB: begin
                library_open_next = 1'b1;
                emit = 1'b1;
                ev   = EV_BGNLIB;
              end
              REC_ENDLIB: begin
                if (!library_open || cell_open) begin
                  stopped_next   = 1'b1;
                  stop_code_next = ST_NEST;
                end else begin
                  library_open_next = 1'b0;
                  emit = 1'b1;
                  ev   = EV_ENDLIB;
                end
              end
              REC_BGNSTR: begin
                if (!library_open) begin
                  stopped_next   = 1'b1;
                  stop_code_next = ST_NEST;
                end else begin
                  cell_open_next = 1'b1;
                  emit = 1'b1;
                  ev   = EV_BGNSTR;
                end
              end
              REC_ENDSTR: begin
                if (!cell_open || elem_on || reference_open) begin
                  stopped_next   = 1'b1;
                  stop_code_next = ST_NEST;
                end else begin
                  cell_open_next = 1'b0;
                  emit = 1'b1;
                  ev   = EV_ENDSTR;
                end
              end
              REC_BOUNDARY, REC_BOX, REC_PATH: begin
                if (!cell_open) begin
                  stopped_next   = 1'b1;
                  stop_code_next = ST_OUTSIDE;
                end else begin
                  emit = 1'b1;
                  if (entry.data[15:0] == REC_BOUNDARY) begin
                    element_kind_next = ELEM_BOUNDARY;
                    ev = EV_BOUNDARY;
                  end else if (entry.data[15:0] == REC_BOX) begin
                    element_kind_next = ELEM_BOX;
                    ev = EV_BOX;
                  end else begin
                    element_kind_next = ELEM_PATH;
                    ev = EV_PATH;
                  end
                end
              end
              REC_SREF: begin
                if (!cell_open) begin
                  stopped_next   = 1'b1;
                  stop_code_next = ST_OUTSIDE;
                end else begin
                  reference_open_next = 1'b1;
                  emit = 1'b1;
                  ev   = EV_SREF;
                end
              end
              REC_ENDEL: begin
                element_kind_next   = ELEM_NONE;
                reference_open_next = 1'b0;
                emit = 1'b1;
                ev   = EV_ENDEL;
              end
              default: ;
            endcase
          end
          OP_XY: begin
            first_v  = entry.data[63:32];
            second_v = entry.data[31:0];
            if (reference_open) begin
              emit = entry.flag;
              ev   = EV_ORIGIN;
            end else if (elem_on) begin
              emit = 1'b1;
              ev   = EV_VERTEX;
            end
          end
          OP_UNITS: begin
            emit   = library_open && entry.flag;
            ev     = EV_UNITS;
            real_v = entry.data;
          end
          OP_MAG, OP_ANGLE: begin
            real_v = entry.data;
            ev     = (entry.op == OP_MAG) ? EV_MAG : EV_ANGLE;
            if (elem_on && reference_open) begin
              stopped_next   = 1'b1;
              stop_code_next = ST_CONFLICT;
            end else begin
              emit = reference_open;
            end
          end
          OP_LAYER: begin
            emit    = elem_on;
            ev      = EV_LAYER;
            first_v = {{16{entry.data[31]}}, entry.data[31:16]};
          end
          OP_WIDTH: begin
            emit    = elem_on;
            ev      = EV_WIDTH;
            first_v = entry.data[31:0];
          end
          OP_PATHTYPE: begin
            emit    = element_kind == ELEM_PATH;
            ev      = EV_PATHTYPE;
            first_v = {{16{entry.data[31]}}, entry.data[31:16]};
          end
          OP_STRANS: begin
            emit    = reference_open;
            ev      = EV_FLIP;
            first_v = {31'd0, entry.data[31]};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      library_open   <= 1'b0;
      cell_open      <= 1'b0;
      element_kind   <= ELEM_NONE;
      reference_open <= 1'b0;
      stopped        <= 1'b0;
      stop_code      <= ST_OK;
      out_valid      <= 1'b0;
    end else begin
      library_open   <= library_open_next;
      cell_open      <= cell_open_next;
      element_kind   <= element_kind_next;
      reference_open <= reference_open_next;
      stopped        <= stopped_next;
      stop_code      <= stop_code_next;
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_event  <= ev;
      out_status <= st;
      out_first  <= first_v;
      out_second <= second_v;
      out_real   <= real_v;
    end
  end

  assign events.valid        = out_valid;
  assign events.event_res    = out_event;
  assign events.status       = out_status;
  assign events.first_value  = out_first;
  assign events.second_value = out_second;
  assign events.raw_real     = out_real;

endmodule

[rtl/gdsii_record_stream_parser_core.sv]
// Channel  Dir  Payload                                                    Transfer
// bytes    in   kind, stream_byte                                          valid && ready
// events   out  event_res, status, first_value, second_value, raw_real     valid && ready
//
// The parser takes one byte per cycle while its entry queue has room.
// A result goes through the entry queue and is then held in an output register.
// A stall on events fills the queue of QUEUE_DEPTH entries before bytes is held off.
// Synchronous reset clears the framing and nesting state and empties the queue.
module gdsii_record_stream_parser_core
  import gdsp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = GDSP_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  gdsp_in_if.sink    bytes,
  gdsp_out_if.source events
);

  q_entry_t wr_entry;
  q_entry_t rd_entry;
  logic     push;
  logic     full;
  logic     q_valid;
  logic     pop;

  gdsp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  gdsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .valid    (q_valid),
    .rd_entry (rd_entry),
    .pop      (pop)
  );

  gdsp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .entry   (rd_entry),
    .pop     (pop),
    .events  (events)
  );

endmodule
